FILE: sv/dfws_pkg.sv
// dfws_pkg: shared types and constants for the synthesiser frequency-word serialiser.
// No dependencies; compile first.
package dfws_pkg;

  localparam int unsigned FrameBits   = 64;
  localparam int unsigned CntW        = $clog2(FrameBits);
  localparam int unsigned FreqW       = 28;
  localparam int unsigned HalfW       = 14;
  localparam int unsigned WordW       = 16;

  localparam logic [WordW-1:0] RESET_HOLD_WORD = 16'h2100;
  localparam logic [WordW-1:0] RELEASE_WORD    = 16'h2000;
  localparam logic [WordW-1:0] TAG_REG_ZERO    = 16'h4000;
  localparam logic [WordW-1:0] TAG_REG_ONE     = 16'h8000;

  // command codes
  localparam logic CMD_FREQ = 1'b0;
  localparam logic CMD_RAW  = 1'b1;

  // bit positions within a run
  localparam logic [CntW-1:0] POS_FIRST      = 6'd0;
  localparam logic [CntW-1:0] POS_WORD0_END  = 6'd15;
  localparam logic [CntW-1:0] POS_FRAME1_BEG = 6'd16;
  localparam logic [CntW-1:0] POS_FRAME1_END = 6'd47;
  localparam logic [CntW-1:0] POS_FRAME2_BEG = 6'd48;
  localparam logic [CntW-1:0] POS_LAST       = 6'd63;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } seq_state_e;

  // sequencer to shift register
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctl_t;

  // frame marks for the bit on the line
  typedef struct packed {
    logic frame_start;
    logic frame_end;
    logic run_last;
  } marks_t;

endpackage

FILE: sv/dfws_if.sv
// dfws_in_if / dfws_out_if: valid-ready channels for command and serial-bit beats.
// Depends on dfws_pkg for field widths.
interface dfws_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [dfws_pkg::FreqW-1:0]   freq_word;
  logic                         reg_select;
  logic [dfws_pkg::WordW-1:0]   raw_word;

  modport source (output valid, cmd, freq_word, reg_select, raw_word, input ready);
  modport sink   (input valid, cmd, freq_word, reg_select, raw_word, output ready);
endinterface

interface dfws_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic frame_start;
  logic frame_end;
  logic run_last;

  modport source (output valid, serial_bit, frame_start, frame_end, run_last, input ready);
  modport sink   (input valid, serial_bit, frame_start, frame_end, run_last, output ready);
endinterface

FILE: sv/dfws_shift.sv
// dfws_shift: 64-bit load/shift register, MSB leaves first.
// Depends on dfws_pkg.
module dfws_shift (
  input  logic                          clk_i,
  input  dfws_pkg::shift_ctl_t          ctl_i,
  input  logic                          cmd_i,
  input  logic [dfws_pkg::FreqW-1:0]    freq_word_i,
  input  logic                          reg_select_i,
  input  logic [dfws_pkg::WordW-1:0]    raw_word_i,
  output logic                          serial_bit_o
);
  import dfws_pkg::*;

  logic [FrameBits-1:0] sreg_q, sreg_d;
  logic [WordW-1:0]     tag, lo_half, hi_half;

  always_comb begin
    tag     = reg_select_i ? TAG_REG_ONE : TAG_REG_ZERO;
    lo_half = tag | {2'b00, freq_word_i[HalfW-1:0]};
    hi_half = tag | {2'b00, freq_word_i[FreqW-1:HalfW]};
    sreg_d  = sreg_q;
    if (ctl_i.load) begin
      if (cmd_i == CMD_RAW) begin
        sreg_d = {raw_word_i, {(FrameBits-WordW){1'b0}}};
      end else begin
        sreg_d = {RESET_HOLD_WORD, lo_half, hi_half, RELEASE_WORD};
      end
    end else if (ctl_i.shift) begin
      sreg_d = {sreg_q[FrameBits-2:0], 1'b0};
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
  end

  assign serial_bit_o = sreg_q[FrameBits-1];

endmodule

FILE: sv/dfws_seq.sv
// dfws_seq: handshake FSM and bit counter; derives frame marks from position.
// Depends on dfws_pkg.
module dfws_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  cmd_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output dfws_pkg::shift_ctl_t  ctl_o,
  output dfws_pkg::marks_t      marks_o
);
  import dfws_pkg::*;

  seq_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            raw_q, raw_d;
  logic            in_fire, out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      raw_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      raw_q   <= raw_d;
    end
  end

  always_comb begin
    marks_o.frame_start = (cnt_q == POS_FIRST) ||
                          (!raw_q && ((cnt_q == POS_FRAME1_BEG) || (cnt_q == POS_FRAME2_BEG)));
    marks_o.frame_end   = (cnt_q == POS_WORD0_END) ||
                          (!raw_q && ((cnt_q == POS_FRAME1_END) || (cnt_q == POS_LAST)));
    marks_o.run_last    = raw_q ? (cnt_q == POS_WORD0_END) : (cnt_q == POS_LAST);

    out_valid_o = (state_q == ST_SEND);
    out_fire    = out_valid_o && out_ready_i;
    // new command loads as the last bit of the current run departs
    in_ready_o  = (state_q == ST_IDLE) || (out_fire && marks_o.run_last);
    in_fire     = in_valid_i && in_ready_o;

    ctl_o.load  = in_fire;
    ctl_o.shift = out_fire;

    state_d = state_q;
    cnt_d   = cnt_q;
    raw_d   = raw_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SEND;
          cnt_d   = POS_FIRST;
          raw_d   = (cmd_i == CMD_RAW);
        end
      end
      ST_SEND: begin
        if (in_fire) begin
          cnt_d = POS_FIRST;
          raw_d = (cmd_i == CMD_RAW);
        end else if (out_fire && marks_o.run_last) begin
          state_d = ST_IDLE;
          cnt_d   = POS_FIRST;
        end else if (out_fire) begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a raw run never counts past its sixteenth bit
  a_raw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && raw_q) |-> (cnt_q <= POS_WORD0_END))
    else $error("raw run counted past its final bit");

  // an accepted command starts a fresh run on the next cycle
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (out_valid_o && (cnt_q == POS_FIRST)))
    else $error("run did not start after command beat");

  // busy sequencer only takes a command while the last bit departs
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && (state_q == ST_SEND)) |-> (out_ready_i && marks_o.run_last))
    else $error("command taken mid-run");

  // a run never stops except after its last bit
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(out_ready_i && marks_o.run_last)) |=> out_valid_o)
    else $error("run ended early");

endmodule

FILE: sv/dds_freq_word_serializer_top.sv
// Serialiser that loads a direct digital synthesiser over a three-wire bus.
// A frequency-load command (cmd = 0) produces three frames, 64 bits in all:
// the reset-hold word 0x2100, a 32-bit frame holding the low then high 14-bit
// halves of freq_word each tagged with the register address (0x4000 for
// register zero, 0x8000 for register one), and the release word 0x2000.
// A raw command (cmd = 1) sends raw_word as a single 16-bit frame. Each output
// beat is one data bit, MSB first, with frame_start/frame_end marking where the
// select line falls and rises, and run_last on the final bit of the command.
// Throughput: one bit per cycle from a 64-bit shift register when the sink
// never stalls; the next command is taken in the cycle the last bit of the
// current one is accepted, so commands stream without gaps. Stalls on the
// output simply hold the current bit. The first bit is presented in the cycle
// after the command beat.
// Depends on dfws_pkg, dfws_if, dfws_shift and dfws_seq.
module dds_freq_word_serializer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfws_in_if.sink     in_i,
  dfws_out_if.source  out_o
);
  import dfws_pkg::*;

  shift_ctl_t ctl;
  marks_t     marks;

  // control: FSM, bit counter and frame-mark decode
  dfws_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .cmd_i       (in_i.cmd),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl),
    .marks_o     (marks)
  );

  // datapath: frame assembly on load, one bit per beat out
  dfws_shift u_shift (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .cmd_i        (in_i.cmd),
    .freq_word_i  (in_i.freq_word),
    .reg_select_i (in_i.reg_select),
    .raw_word_i   (in_i.raw_word),
    .serial_bit_o (out_o.serial_bit)
  );

  assign out_o.frame_start = marks.frame_start;
  assign out_o.frame_end   = marks.frame_end;
  assign out_o.run_last    = marks.run_last;

endmodule
